FILE: rtl/fsr_pkg.sv
// Shared constants and table-building functions for the fringe-stop phase rotator.
// No dependencies.
package fsr_pkg;

  // Frequency plan, Hz
  localparam logic [29:0] CHAN_HZ      = 30'd976;
  localparam logic [29:0] HALF_CHAN_HZ = 30'd488;
  localparam logic [29:0] BASE_HZ      = 30'd224000000;
  localparam int          FREQ_W       = 30;

  // Trig value: sign plus 18-bit magnitude of round(2^17*sin)
  localparam int TRIG_W = 19;
  localparam int MAG_W  = 18;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_RATE      = 3'd1;
  localparam logic [2:0] REG_START     = 3'd2;
  localparam logic [2:0] REG_COS_COEFF = 3'd3;
  localparam logic [2:0] REG_SIN_COEFF = 3'd4;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // (a*b) >> 62, truncated to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(2^17*sin(pi/2*k/2^qbits)) through an integer Taylor series
  function automatic logic [MAG_W-1:0] quadrant_sin(input int unsigned k, input int qbits);
    logic [63:0] x, x2, term, sum, kk, mask;
    logic [63:0] r;
    kk   = 64'(k);
    mask = (64'd1 << qbits) - 64'd1;
    x    = (HALF_PI_Q62 >> qbits) * kk + (((HALF_PI_Q62 & mask) * kk) >> qbits);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    r = (sum + (64'd1 << 44)) >> 45;
    return r[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/fsr_trig_rom.sv
// Dual-read sine/cosine ROM built from a quarter-wave table, registered outputs.
// Depends on fsr_pkg.
module fsr_trig_rom #(
  parameter int TRIG_ADDRESS_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [TRIG_ADDRESS_BITS-1:0]         sin_idx,
  input  logic [TRIG_ADDRESS_BITS-1:0]         cos_idx,
  output logic signed [fsr_pkg::TRIG_W-1:0]    sin_val,
  output logic signed [fsr_pkg::TRIG_W-1:0]    cos_val
);
  import fsr_pkg::*;

  localparam int TB = TRIG_ADDRESS_BITS;
  localparam int QN = 1 << (TB - 2);

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t qtab_t [0:QN];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QN; k++) begin
      t[k] = quadrant_sin(k, TB - 2);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam logic [TB-1:0] HALF  = TB'(1 << (TB - 1));
  localparam logic [TB-1:0] QUART = TB'(QN);

  logic [TB-1:0] cos_full;
  logic [TB-1:0] s_q, c_q;
  logic [TB-2:0] s_addr, c_addr;
  mag_t          s_mag, c_mag;
  logic          s_neg, c_neg;

  // Fold a full-turn index into the quarter table
  assign cos_full = cos_idx;
  always_comb begin
    s_q = {1'b0, sin_idx[TB-2:0]};
    if (s_q > QUART) s_q = HALF - s_q;
    c_q = {1'b0, cos_full[TB-2:0]};
    if (c_q > QUART) c_q = HALF - c_q;
  end
  assign s_addr = s_q[TB-2:0];
  assign c_addr = c_q[TB-2:0];

  // Registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      s_mag <= QTAB[s_addr];
      c_mag <= QTAB[c_addr];
      s_neg <= sin_idx[TB-1];
      c_neg <= cos_full[TB-1];
    end
  end

  assign sin_val = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign cos_val = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

endmodule

FILE: rtl/fringe_stop_phase_rotator.sv
// Fringe-stopping / delay-tracking phase rotator, top level.
// Uses fsr_pkg and fsr_trig_rom.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one complex sample with its
//   beamlet, channel and elapsed time. Output channel (out_valid/out_stall)
//   carries the rotated sample and a saturation flag, one per input.
//   Throughput is one transaction per cycle while the output is not stalled. The eight
//   register stages are: hour-angle products, first trig lookup, delay
//   coefficient products, delay sum, frequency-delay products, phase trig
//   lookup, sample products, round/saturate output register.
//   A stall on the output freezes the whole pipeline; in_stall rises only
//   while the output stage holds a result and out_stall is high, so nothing
//   is dropped or repeated.
//   Reset empties the pipeline and loads the configuration defaults
//   (enabled, default rotation rate, zero angle and coefficients).
//   Configuration is written through cfg_we/cfg_index/cfg_data; write only
//   while the pipeline is empty.
//   With fringe_enable low, samples pass through unchanged, saturated = 0.
module fringe_stop_phase_rotator #(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int BEAMLET_SIZE      = 256,
  parameter int TRIG_ADDRESS_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [39:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
  input  logic [7:0]                     beamlet,
  input  logic [7:0]                     channel,
  input  logic [31:0]                    elapsed_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im,
  output logic                           saturated
);
  import fsr_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int TB    = TRIG_ADDRESS_BITS;
  localparam int NSTG  = 8;
  localparam int PW    = SW + TRIG_W;
  localparam int SUMW  = PW + 1;
  localparam int YW    = SUMW - 17;
  localparam logic [TB-1:0] QUART = TB'(1 << (TB - 2));
  localparam logic [FREQ_W-1:0] BEAM_HZ = FREQ_W'(BEAMLET_SIZE * 976);

  // Configuration registers
  logic               fringe_enable;
  logic [39:0]        rotation_rate;
  logic [31:0]        start_angle;
  logic signed [39:0] delay_cos_coeff;
  logic signed [39:0] delay_sin_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fringe_enable   <= 1'b1;
      rotation_rate   <= 40'd3266700000;
      start_angle     <= 32'd0;
      delay_cos_coeff <= 40'sd0;
      delay_sin_coeff <= 40'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    fringe_enable   <= cfg_data[0];
        REG_RATE:      rotation_rate   <= cfg_data;
        REG_START:     start_angle     <= cfg_data[31:0];
        REG_COS_COEFF: delay_cos_coeff <= $signed(cfg_data);
        REG_SIN_COEFF: delay_sin_coeff <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline control: one enable for all stages
  logic [NSTG:1] vld;
  logic          adv;

  assign adv      = !(vld[NSTG] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-1:1], in_valid};
    end
  end

  // Sample and mode carried alongside
  logic signed [SW-1:0] re_p [1:7];
  logic signed [SW-1:0] im_p [1:7];
  logic                 en_p [1:7];
  logic [FREQ_W-1:0]    freq_p [1:4];

  always_ff @(posedge clk) begin
    if (adv) begin
      re_p[1]   <= sample_re;
      im_p[1]   <= sample_im;
      en_p[1]   <= fringe_enable;
      freq_p[1] <= {22'd0, beamlet} * BEAM_HZ + {22'd0, channel} * CHAN_HZ
                   + HALF_CHAN_HZ + BASE_HZ;
      for (int i = 2; i <= 7; i++) begin
        re_p[i] <= re_p[i-1];
        im_p[i] <= im_p[i-1];
        en_p[i] <= en_p[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        freq_p[i] <= freq_p[i-1];
      end
    end
  end

  // Stage 1: hour-angle partial products
  logic [63:0] ha_lo;
  logic [31:0] ha_hi;
  logic [39:0] ha_hi_full;

  assign ha_hi_full = {8'd0, elapsed_time} * {32'd0, rotation_rate[39:32]};

  always_ff @(posedge clk) begin
    if (adv) begin
      ha_lo <= {32'd0, elapsed_time} * {32'd0, rotation_rate[31:0]};
      ha_hi <= ha_hi_full[31:0];
    end
  end

  // Stage 2: hour angle and first trig lookup
  logic [31:0]                 hour_angle;
  logic [TB-1:0]               ha_idx;
  logic signed [TRIG_W-1:0]    ha_sin, ha_cos;

  assign hour_angle = ha_lo[63:32] + ha_hi + start_angle;
  assign ha_idx     = hour_angle[31 -: TB];

  fsr_trig_rom #(.TRIG_ADDRESS_BITS(TB)) u_ha_rom (
    .clk     (clk),
    .en      (adv),
    .sin_idx (ha_idx),
    .cos_idx (ha_idx + QUART),
    .sin_val (ha_sin),
    .cos_val (ha_cos)
  );

  // Stage 3: delay coefficient products
  logic signed [58:0] cos_term, sin_term;

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_term <= delay_cos_coeff * ha_cos;
      sin_term <= delay_sin_coeff * ha_sin;
    end
  end

  // Stage 4: delay, floor shift by 17
  logic signed [59:0] delay_sum;
  logic signed [42:0] delay;

  assign delay_sum = 60'(cos_term) + 60'(sin_term);

  always_ff @(posedge clk) begin
    if (adv) begin
      delay <= 43'(delay_sum >>> 17);
    end
  end

  // Stage 5: frequency times delay, split in two narrower products
  logic [47:0] delay48;
  logic [53:0] fd_lo;
  logic [23:0] fd_hi;
  logic [53:0] fd_hi_full;

  assign delay48    = {{5{delay[42]}}, delay};
  assign fd_hi_full = {24'd0, freq_p[4]} * {30'd0, delay48[47:24]};

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_lo <= {24'd0, freq_p[4]} * {30'd0, delay48[23:0]};
      fd_hi <= fd_hi_full[23:0];
    end
  end

  // Stage 6: phase and second trig lookup
  logic [47:0]              fd_prod;
  logic [TB-1:0]            ph_idx;
  logic signed [TRIG_W-1:0] ph_sin, ph_cos;

  assign fd_prod = fd_lo[47:0] + {fd_hi, 24'd0};
  assign ph_idx  = fd_prod[47 -: TB];

  fsr_trig_rom #(.TRIG_ADDRESS_BITS(TB)) u_ph_rom (
    .clk     (clk),
    .en      (adv),
    .sin_idx (ph_idx),
    .cos_idx (ph_idx + QUART),
    .sin_val (ph_sin),
    .cos_val (ph_cos)
  );

  // Stage 7: complex multiply products
  logic signed [PW-1:0] p_rc, p_is, p_rs, p_ic;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rc <= re_p[6] * ph_cos;
      p_is <= im_p[6] * ph_sin;
      p_rs <= re_p[6] * ph_sin;
      p_ic <= im_p[6] * ph_cos;
    end
  end

  // Stage 8: round half up, saturate, output register
  localparam logic signed [SUMW-1:0] RND = SUMW'(1 << 16);
  localparam logic signed [YW-1:0] YMAX = YW'((1 << (SW - 1)) - 1);
  localparam logic signed [YW-1:0] YMIN = -YMAX - YW'(1);

  logic signed [SUMW-1:0] sum_re, sum_im;
  logic signed [YW-1:0]   y_re, y_im;
  logic signed [SW-1:0]   sat_re, sat_im;
  logic                   clip_re, clip_im;

  assign sum_re = SUMW'(p_rc) - SUMW'(p_is) + RND;
  assign sum_im = SUMW'(p_rs) + SUMW'(p_ic) + RND;
  assign y_re   = YW'(sum_re >>> 17);
  assign y_im   = YW'(sum_im >>> 17);

  always_comb begin
    clip_re = 1'b0;
    clip_im = 1'b0;
    sat_re  = SW'(y_re);
    sat_im  = SW'(y_im);
    if (y_re > YMAX) begin
      sat_re  = SW'(YMAX);
      clip_re = 1'b1;
    end else if (y_re < YMIN) begin
      sat_re  = SW'(YMIN);
      clip_re = 1'b1;
    end
    if (y_im > YMAX) begin
      sat_im  = SW'(YMAX);
      clip_im = 1'b1;
    end else if (y_im < YMIN) begin
      sat_im  = SW'(YMIN);
      clip_im = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (en_p[7]) begin
        out_re    <= sat_re;
        out_im    <= sat_im;
        saturated <= clip_re | clip_im;
      end else begin
        out_re    <= re_p[7];
        out_im    <= im_p[7];
        saturated <= 1'b0;
      end
    end
  end

  assign out_valid = vld[NSTG];

  // Checks
  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted transaction not in first stage");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (out_re == SW'(YMAX) || out_re == SW'(YMIN) ||
                                  out_im == SW'(YMAX) || out_im == SW'(YMIN)))
    else $error("saturation flag without a clipped part");

endmodule
